/* hw/rtl/dms_pkg.sv */
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types, field widths and the sort order for the record sorter.
// ----------------------------------------------------------------------------
package dms_pkg;

	localparam int DMS_CAPACITY  = 64;
	localparam int DMS_NUM_SLOTS = 4;

	localparam int ID_W     = 9;
	localparam int LEVEL_W  = 7;
	localparam int METHOD_W = 3;
	localparam int SLOT_W   = 3;
	localparam int POS_W    = 6;

	localparam int IN_FIELDS_W  = ID_W + LEVEL_W + METHOD_W + SLOT_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = ID_W + LEVEL_W + METHOD_W + SLOT_W + POS_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [SLOT_W-1:0] NOT_HELD = SLOT_W'(4);

	// action codes carried on the input tuser bit
	typedef enum logic {
		ACT_ADD    = 1'b0,
		ACT_FINISH = 1'b1
	} action_t;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [LEVEL_W-1:0]  level;
		logic [METHOD_W-1:0] method;
		logic [SLOT_W-1:0]   slot;
		logic                equipped;
	} rec_t;

	// command broadcast to every cell
	typedef struct packed {
		logic add;
		logic sort;
		logic phase;
		logic shift;
		rec_t rec;
	} cell_ctl_t;

	// true when a must come after b
	function automatic logic goes_after(input rec_t a, input rec_t b);
		logic r;
		if (a.equipped != b.equipped) begin
			r = b.equipped;
		end else if (a.method != b.method) begin
			r = a.method > b.method;
		end else if (a.method == '0) begin
			r = a.level > b.level;
		end else begin
			r = a.id > b.id;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/dedup_record_multikey_sorter_top.sv */
// ----------------------------------------------------------------------------
// dedup_record_multikey_sorter_top
// Deduplicating record table with a stable multi-key sort and burst output.
// ----------------------------------------------------------------------------
// On an add transaction every cell compares its id at once, so a duplicate is
// updated to a lower method or a new record appended in the cycle it arrives.
// A finish transaction runs odd-even compare-swap rounds across the cell row,
// then shifts the row out through the output register at one result per
// cycle while m_tready stays high; an empty table gives one result with tuser
// low. New input is taken again once the last result is in the output
// register.
module dedup_record_multikey_sorter_top #(
	parameter int CAPACITY  = dms_pkg::DMS_CAPACITY,
	parameter int NUM_SLOTS = dms_pkg::DMS_NUM_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// entry_id, entry_level, entry_method, held_slot, zero pad
	input  logic [dms_pkg::IN_DATA_W-1:0]    s_tdata,
	// action
	input  logic [0:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_id, out_level, out_method, out_slot, out_position, zero pad
	output logic [dms_pkg::OUT_DATA_W-1:0]   m_tdata,
	// out_valid
	output logic [0:0]                       m_tuser,
	output logic                             m_tlast
);
	import dms_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SORT = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  round_q;
	logic [POS_W-1:0]  pos_q;

	rec_t              out_rec_q;
	logic [POS_W-1:0]  out_pos_q;
	logic              out_valid_q;
	logic              out_last_q;
	logic              m_tvalid_q;

	rec_t              in_rec;
	logic [SLOT_W-1:0] in_slot;
	logic              in_equipped;
	logic              s_accept;
	logic              do_add;
	logic              do_finish;
	logic              emit_load;
	logic              hit;
	cell_ctl_t         ctl;

	rec_t              cell_rec [CAPACITY];
	logic [CAPACITY-1:0] swap;
	logic [CAPACITY-1:0] match;

	// input unpack
	assign in_slot     = s_tdata[IN_FIELDS_W-1 -: SLOT_W];
	assign in_equipped = {1'b0, in_slot} < (SLOT_W + 1)'(NUM_SLOTS);
	assign in_rec.id       = s_tdata[ID_W-1:0];
	assign in_rec.level    = s_tdata[ID_W +: LEVEL_W];
	assign in_rec.method   = s_tdata[ID_W + LEVEL_W +: METHOD_W];
	assign in_rec.slot     = in_equipped ? in_slot : NOT_HELD;
	assign in_rec.equipped = in_equipped;

	assign s_tready  = state_q == ST_IDLE;
	assign s_accept  = s_tvalid && s_tready;
	assign do_add    = s_accept && (action_t'(s_tuser[0]) == ACT_ADD)
		&& (in_rec.id != '0) && (count_q < CNT_W'(CAPACITY));
	assign do_finish = s_accept && (action_t'(s_tuser[0]) == ACT_FINISH);
	assign emit_load = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	assign hit       = |match;

	always_comb begin
		ctl.add   = do_add;
		ctl.sort  = state_q == ST_SORT;
		ctl.phase = round_q[0];
		ctl.shift = emit_load && (count_q != '0);
		ctl.rec   = in_rec;
	end

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			dms_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.hit       (hit),
				.count     (count_q),
				.left_rec  (cell_rec[i]),
				.right_rec (cell_rec[i+1]),
				.swap_in   (1'b0),
				.swap_out  (swap[i]),
				.match     (match[i]),
				.rec       (cell_rec[i])
			);
		end else if (i == CAPACITY - 1) begin : g_last
			dms_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.hit       (hit),
				.count     (count_q),
				.left_rec  (cell_rec[i-1]),
				.right_rec (cell_rec[i]),
				.swap_in   (swap[i-1]),
				.swap_out  (swap[i]),
				.match     (match[i]),
				.rec       (cell_rec[i])
			);
		end else begin : g_mid
			dms_cell #(.CAPACITY(CAPACITY), .INDEX(i)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.hit       (hit),
				.count     (count_q),
				.left_rec  (cell_rec[i-1]),
				.right_rec (cell_rec[i+1]),
				.swap_in   (swap[i-1]),
				.swap_out  (swap[i]),
				.match     (match[i]),
				.rec       (cell_rec[i])
			);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			round_q    <= '0;
			pos_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// load a result, or drop the one just taken
			if (emit_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_add && !hit) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (do_finish) begin
						round_q <= '0;
						pos_q   <= '0;
						state_q <= (count_q == '0) ? ST_EMIT : ST_SORT;
					end
				end
				ST_SORT: begin
					round_q <= round_q + CNT_W'(1);
					if (round_q == count_q - CNT_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (count_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							count_q <= count_q - CNT_W'(1);
							pos_q   <= pos_q + POS_W'(1);
							if (count_q == CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit_load) begin
			if (count_q == '0) begin
				out_rec_q   <= '0;
				out_pos_q   <= '0;
				out_valid_q <= 1'b0;
				out_last_q  <= 1'b1;
			end else begin
				out_rec_q   <= cell_rec[0];
				out_pos_q   <= pos_q;
				out_valid_q <= 1'b1;
				out_last_q  <= count_q == CNT_W'(1);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_pos_q, out_rec_q.slot,
		out_rec_q.method, out_rec_q.level, out_rec_q.id};
	assign m_tuser  = out_valid_q;
	assign m_tlast  = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("empty-table result without last");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && (count_q <= CNT_W'(1))) |=> (state_q == ST_IDLE && count_q == '0))
		else $error("table not cleared after last result");

	a_add_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=>
		(count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1)))
		else $error("add transaction moved count by more than one");

	a_no_swap_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |-> !(|(swap[CAPACITY-2:0] & swap[CAPACITY-1:1])))
		else $error("adjacent compare-swap pairs overlap");

endmodule

/* hw/rtl/dms_cell.sv */
// ----------------------------------------------------------------------------
// dms_cell
// One table entry: id match for duplicates, append write, a compare-swap
// with either neighbor during the sort, and a left shift while emitting.
// ----------------------------------------------------------------------------
module dms_cell #(
	parameter int CAPACITY = dms_pkg::DMS_CAPACITY,
	parameter int INDEX    = 0
) (
	input  logic                                clk,
	input  dms_pkg::cell_ctl_t                  ctl,
	input  logic                                hit,
	input  logic [$clog2(CAPACITY+1)-1:0]       count,
	input  dms_pkg::rec_t                       left_rec,
	input  dms_pkg::rec_t                       right_rec,
	input  logic                                swap_in,
	output logic                                swap_out,
	output logic                                match,
	output dms_pkg::rec_t                       rec
);
	import dms_pkg::*;

	localparam int   CNT_W  = $clog2(CAPACITY + 1);
	localparam logic PARITY = 1'(INDEX % 2);

	rec_t rec_q;
	logic live;
	logic right_live;
	logic at_tail;

	assign live       = count > CNT_W'(INDEX);
	assign right_live = count > CNT_W'(INDEX + 1);
	assign at_tail    = count == CNT_W'(INDEX);
	assign match      = live && (rec_q.id == ctl.rec.id);

	// lower cell of the active pair decides the swap for both
	assign swap_out = ctl.sort && (ctl.phase == PARITY) && right_live
		&& goes_after(rec_q, right_rec);

	always_ff @(posedge clk) begin
		if (ctl.add) begin
			if (hit) begin
				if (match && (ctl.rec.method < rec_q.method)) begin
					rec_q.method <= ctl.rec.method;
					rec_q.level  <= ctl.rec.level;
				end
			end else if (at_tail) begin
				rec_q <= ctl.rec;
			end
		end else if (ctl.sort) begin
			if (swap_out) begin
				rec_q <= right_rec;
			end else if (swap_in) begin
				rec_q <= left_rec;
			end
		end else if (ctl.shift) begin
			rec_q <= right_rec;
		end
	end

	assign rec = rec_q;

endmodule
